/* src/sial_pkg.sv */
// sial_pkg: shared widths, operation codes and the cell command enum
// for the shift_insert_array_list block. No dependencies.
`default_nettype none

package sial_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_APPEND = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,  // cell at target takes the new value
    CELL_SHUP  = 2'd2,  // insert: above target take left neighbor, target takes new value
    CELL_SHDN  = 2'd3   // remove: at/above target take right neighbor
  } cell_op_e;

endpackage

`default_nettype wire

/* src/sial_cell.sv */
// sial_cell: one storage cell of the list; holds one element and exchanges
// data with its neighbors. Depends on sial_pkg.
`default_nettype none

module sial_cell import sial_pkg::*; #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned Idx  = 0
) (
  input  wire logic                     clk_i,
  input  wire cell_op_e                 op_i,
  input  wire logic [IdxW-1:0]          tgt_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic signed [DATA_W-1:0] left_i,
  input  wire logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0]      data_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic signed [DATA_W-1:0] data_d, data_q;
  logic                     at_tgt, above_tgt;

  assign at_tgt    = (tgt_i == MyIdx);
  assign above_tgt = (MyIdx > tgt_i);

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      CELL_HOLD: data_d = data_q;
      CELL_LOAD: begin
        if (at_tgt) data_d = value_i;
      end
      CELL_SHUP: begin
        if (above_tgt)   data_d = left_i;
        else if (at_tgt) data_d = value_i;
      end
      CELL_SHDN: begin
        if (above_tgt || at_tgt) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* src/shift_insert_array_list.sv */
// A result is in the output register in the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; every cell shifts or
// loads in parallel, so insert and remove take no longer than read or overwrite.
// Input stalls only while a result waits in the output register and out_ready_i is low.
// Reset (rst_ni low, async): length count and output valid clear; element
// contents stay undefined until written.
`default_nettype none

module shift_insert_array_list import sial_pkg::*; #(
  parameter int unsigned Capacity = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // item channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [KIND_W-1:0]        kind_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      read_value_o,
  output logic [LEN_W-1:0]              length_o,
  output logic [STAT_W-1:0]             status_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  // compare width wide enough for both count and position
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [CmpW-1:0] CapCmp = CmpW'(Capacity);

  logic [CntW-1:0]          count_d, count_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] rd_d, rd_q;
  logic [LEN_W-1:0]         len_q;
  status_e                  st_d, st_q;
  logic                     xfer_in;

  cell_op_e                 op;
  logic [IdxW-1:0]          tgt;
  logic [CmpW-1:0]          cnt_cmp, pos_cmp;
  logic signed [DATA_W-1:0] cell_data [Capacity];
  logic signed [DATA_W-1:0] sel_data;

  assign xfer_in    = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign cnt_cmp = CmpW'(count_q);
  assign pos_cmp = CmpW'(position_i);

  // Read port: AND-OR select over the row of cells
  always_comb begin
    sel_data = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (pos_cmp == CmpW'(i)) sel_data = sel_data | cell_data[i];
    end
  end

  // Decode: range/full checks, cell command, next count and status
  always_comb begin
    op      = CELL_HOLD;
    tgt     = IdxW'(position_i);
    count_d = count_q;
    rd_d    = '0;
    st_d    = ST_OK;
    unique case (kind_i)
      KIND_READ: begin
        if (pos_cmp >= cnt_cmp) st_d = ST_RANGE;
        else                    rd_d = sel_data;
      end
      KIND_WRITE: begin
        if (pos_cmp >= cnt_cmp) st_d = ST_RANGE;
        else                    op   = CELL_LOAD;
      end
      KIND_APPEND: begin
        if (cnt_cmp >= CapCmp) begin
          st_d = ST_FULL;
        end else begin
          op      = CELL_LOAD;
          tgt     = IdxW'(count_q);
          count_d = count_q + CntW'(1);
        end
      end
      KIND_INSERT: begin
        // range check ranks above full
        if (pos_cmp > cnt_cmp) begin
          st_d = ST_RANGE;
        end else if (cnt_cmp >= CapCmp) begin
          st_d = ST_FULL;
        end else begin
          op      = CELL_SHUP;
          count_d = count_q + CntW'(1);
        end
      end
      KIND_REMOVE: begin
        if (pos_cmp >= cnt_cmp) begin
          st_d = ST_RANGE;
        end else begin
          op      = CELL_SHDN;
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        // unused kinds: no change, ok status
      end
    endcase
    if (!xfer_in) begin
      op      = CELL_HOLD;
      count_d = count_q;
    end
  end

  // Row of cells; ends fed with don't-care neighbors
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    sial_cell #(
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .tgt_i   (tgt),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (xfer_in)          out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result register, loaded on every input transfer
  always_ff @(posedge clk_i) begin
    if (xfer_in) begin
      rd_q  <= rd_d;
      len_q <= LEN_W'(count_d);
      st_q  <= st_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_q;
  assign length_o     = len_q;
  assign status_o     = st_q;

endmodule

`default_nettype wire

/* src/sial_checker.sv */
// sial_checker: port-level assertions for shift_insert_array_list, attached
// by the bind at the end of this file. Depends on sial_pkg.
`default_nettype none

module sial_checker import sial_pkg::*; #(
  parameter int unsigned Capacity = CAPACITY_DEF
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic [KIND_W-1:0]        kind_i,
  input wire logic [POS_W-1:0]         position_i,
  input wire logic signed [DATA_W-1:0] value_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic signed [DATA_W-1:0] read_value_o,
  input wire logic [LEN_W-1:0]         length_o,
  input wire logic [STAT_W-1:0]        status_o
);

  localparam logic [LEN_W-1:0] CapLen = LEN_W'(Capacity);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(length_o) && $stable(status_o))
    else $error("result changed while stalled");

  // only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_RANGE || status_o == ST_FULL))
    else $error("undefined status code");

  // failed operations never return data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0)
    else $error("nonzero read value with error status");

  // full is reported only at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> length_o == CapLen)
    else $error("full status below capacity");

  // input ready whenever the result register is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind shift_insert_array_list sial_checker #(.Capacity(Capacity)) u_sial_checker (.*);

`default_nettype wire

/* bench/sial_list_checker.sv */
`timescale 1ns / 1ps
// sial_list_checker: watches both channels of shift_insert_array_list, keeps its own
// copy of the list, predicts every result and compares it field by field.
// Depends on sial_pkg.
`default_nettype none

module sial_list_checker import sial_pkg::*; #(
  parameter int Capacity = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic [KIND_W-1:0]        kind_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic signed [DATA_W-1:0] read_value_i,
  input  wire logic [LEN_W-1:0]         length_i,
  input  wire logic [STAT_W-1:0]        status_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
    status_e                  status;
  } list_result_t;

  logic signed [DATA_W-1:0] list_store [Capacity];
  int                       list_len;
  list_result_t             expected_results [$];
  int                       mismatches;

  assign fail_count_o = mismatches;

  initial begin
    list_len   = 0;
    mismatches = 0;
    pending_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Applies one list operation to the shadow list and returns its result.
  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                 input logic [POS_W-1:0] pos_bits,
                                                 input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           pos;
    int           j;
    res.read_value = '0;
    res.status     = ST_OK;
    pos            = int'(pos_bits);
    case (kind)
      KIND_READ: begin
        if (pos >= list_len) res.status = ST_RANGE;
        else res.read_value = list_store[pos];
      end
      KIND_WRITE: begin
        if (pos >= list_len) res.status = ST_RANGE;
        else list_store[pos] = val;
      end
      KIND_APPEND: begin
        if (list_len >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          list_store[list_len] = val;
          list_len++;
        end
      end
      KIND_INSERT: begin
        // range check wins over the full check
        if (pos > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          for (j = list_len; j > pos; j--) list_store[j] = list_store[j-1];
          list_store[pos] = val;
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (j = pos; j + 1 < list_len; j++) list_store[j] = list_store[j+1];
          list_len--;
        end
      end
      default: ;  // spare kinds: no effect, status ok
    endcase
    res.length = LEN_W'(list_len);
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    list_result_t want;
    if (rst_ni) begin
      // result transfer first: results are registered, so a result never belongs to
      // an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: rd=%0d len=%0d st=%0d",
                                    read_value_i, length_i, status_i));
        end else begin
          want = expected_results.pop_front();
          if (read_value_i !== want.read_value)
            report_mismatch($sformatf("read_value got %0d exp %0d",
                                      read_value_i, want.read_value));
          if (length_i !== want.length)
            report_mismatch($sformatf("length got %0d exp %0d", length_i, want.length));
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0d exp %0d", status_i, want.status));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_list_op(kind_i, position_i, value_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for shift_insert_array_list; result checking lives in
// sial_list_checker. Depends on sial_pkg, the block and the checker.
`default_nettype none

module tb;
  import sial_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int LONG_HOLD      = 400;   // receiver hold-off, longer than any fill-up
  localparam int RANDOM_ITEMS   = 760;
  localparam int QUIET_ITEMS    = 120;   // tail of the run with no idling
  localparam int MODE_GROW      = 0;
  localparam int MODE_SHRINK    = 1;
  localparam int MODE_MIXED     = 2;
  // kinds the block must treat as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [KIND_W-1:0]        kind_i;
  logic [POS_W-1:0]         position_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] read_value_o;
  logic [LEN_W-1:0]         length_o;
  logic [STAT_W-1:0]        status_o;

  int fail_count;
  int pending;

  // stimulus-side bookkeeping: tracks the list length only to aim positions
  int   len_est;
  logic quiet;     // no idling on either side
  bit   calm;      // no sender gaps in the current phase
  int   hold_req_n;
  int   hold_seen_n;
  int   low_left;
  int   idle_cycles;

  shift_insert_array_list u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .length_o     (length_o),
    .status_o     (status_o)
  );

  sial_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_i (read_value_o),
    .length_i     (length_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Receiver pacing: random stall bursts, plus one long hold-off on request
  // so the output register fills and the block backs up its input.
  always @(posedge clk_i) begin : rx_pacing
    int low_next;
    low_next = 0;
    if (hold_req_n != hold_seen_n) begin
      hold_seen_n = hold_req_n;
      low_next    = LONG_HOLD;
    end else if (low_left > 0) begin
      low_next = low_left;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      low_next = $urandom_range(1, 19);
    end
    out_ready_i <= (low_next == 0);
    low_left    <= (low_next > 0) ? low_next - 1 : 0;
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transfer, with an optional gap ahead of it. Valid stays up
  // across back-to-back items, so it gets a single assignment per edge.
  task automatic send_op(input logic [KIND_W-1:0] kind, input int pos,
                         input logic signed [DATA_W-1:0] val);
    int gap;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    position_i <= POS_W'(pos);
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (kind)
      KIND_APPEND: if (len_est < CAPACITY_DEF) len_est++;
      KIND_INSERT: if (pos <= len_est && len_est < CAPACITY_DEF) len_est++;
      KIND_REMOVE: if (pos < len_est) len_est--;
      default: ;
    endcase
  endtask

  // Random item: kind mix depends on the phase, positions mostly in range.
  task automatic send_random(input int mode);
    int                roll;
    int                top;
    int                pos;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:
        kind = roll < 40 ? KIND_APPEND : roll < 80 ? KIND_INSERT : roll < 88 ? KIND_READ :
               roll < 95 ? KIND_WRITE : KIND_REMOVE;
      MODE_SHRINK:
        kind = roll < 60 ? KIND_REMOVE : roll < 75 ? KIND_READ : roll < 85 ? KIND_WRITE :
               roll < 95 ? KIND_INSERT : KIND_APPEND;
      default:
        kind = roll < 30 ? KIND_READ : roll < 55 ? KIND_WRITE : roll < 67 ? KIND_APPEND :
               roll < 82 ? KIND_INSERT : roll < 97 ? KIND_REMOVE :
               KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    endcase
    top = (kind == KIND_INSERT) ? len_est : (len_est > 0 ? len_est - 1 : 0);
    pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CAPACITY_DEF)
                                     : $urandom_range(0, top);
    send_op(kind, pos, $urandom);
  endtask

  // Sender pause: returns once every result owed has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int run;
    int mode;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_READ;
    position_i  = '0;
    value_i     = '0;
    out_ready_i = 1'b0;
    quiet       = 1'b0;
    calm        = 1'b0;
    len_est     = 0;
    hold_req_n  = 0;
    hold_seen_n = 0;
    low_left    = 0;
    idle_cycles = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // empty list: read, write and remove out of range, insert past the end
    send_op(KIND_READ,   0, 32'sd0);
    send_op(KIND_WRITE,  0, 32'sd1);
    send_op(KIND_REMOVE, 0, 32'sd0);
    send_op(KIND_INSERT, 1, 32'sd2);
    // value extremes, insert at front, at the end and in the middle
    send_op(KIND_INSERT, 0, 32'sh8000_0000);
    send_op(KIND_APPEND, 0, 32'sh7fff_ffff);
    send_op(KIND_APPEND, 0, -32'sd1);
    send_op(KIND_INSERT, 3, 32'sd0);
    send_op(KIND_INSERT, 1, 32'sh5555_5555);
    for (int i = 0; i <= 5; i++) send_op(KIND_READ, i, 32'sd0);  // last one out of range
    send_op(KIND_WRITE,  4, 32'shaaaa_aaaa);
    send_op(KIND_READ,   4, 32'sd0);
    send_op(KIND_REMOVE, 0, 32'sd0);
    send_op(KIND_REMOVE, 3, 32'sd0);                 // remove the last entry
    send_op(KIND_READ,   CAPACITY_DEF, 32'sd0);
    send_op(KIND_INSERT, CAPACITY_DEF, 32'sd3);      // past the end, not full
    for (logic [KIND_W-1:0] k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_op(k, 0, -32'sd1);
      if (k == KIND_SPARE_LAST) break;
    end

    // --- fill to capacity, then hit the full-list cases ---
    while (len_est < CAPACITY_DEF) send_op(KIND_APPEND, 0, $urandom);
    send_op(KIND_APPEND, 0, $urandom);
    send_op(KIND_INSERT, 0, $urandom);
    send_op(KIND_INSERT, CAPACITY_DEF, $urandom);    // in range but full
    send_op(KIND_WRITE,  CAPACITY_DEF - 1, 32'sh7fff_ffff);
    send_op(KIND_READ,   CAPACITY_DEF - 1, 32'sd0);
    send_op(KIND_REMOVE, CAPACITY_DEF, 32'sd0);
    send_op(KIND_REMOVE, CAPACITY_DEF - 1, 32'sd0);

    // sender pause until all results are in
    wait_drained();

    // long receiver hold-off while items keep coming: the block backs up
    hold_req_n++;
    calm = 1'b1;
    repeat (40) send_random(MODE_MIXED);

    // --- random phases ---
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(MODE_GROW, MODE_MIXED);
      run  = $urandom_range(20, 80);
      calm = ($urandom_range(0, 3) == 0);
      repeat (run) begin
        if (sent == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
        send_random(mode);
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    // drain, then let the clock run on for anything stray
    wait_drained();
    repeat (4) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
